// ===== rtl/core/iopd_pkg.sv =====
// Shared types and constants of the I/O port decoder and memory pager.
package iopd_pkg;

  // Storage sizes
  localparam int KEY_ROW_COUNT   = 8;
  localparam int SOUND_REG_COUNT = 16;
  localparam int KEY_ROW_IDX_W   = (KEY_ROW_COUNT > 1) ? $clog2(KEY_ROW_COUNT) : 1;
  localparam int SOUND_SEL_W     = $clog2(SOUND_REG_COUNT);

  // Stream and config widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Function codes
  localparam logic [1:0] FUNC_READ     = 2'd0;
  localparam logic [1:0] FUNC_WRITE    = 2'd1;
  localparam logic [1:0] FUNC_ROW_LOAD = 2'd2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_READ = 1'd1;

  // Port decode, low byte
  localparam logic [7:0] LO_SOUND = 8'hFD;
  localparam logic [7:0] LO_JOY   = 8'h1F;
  localparam logic [7:0] LO_ULA   = 8'hFE;

  // Port decode, high byte under LO_SOUND
  localparam logic [7:0] HI_SOUND_SEL  = 8'hFF;
  localparam logic [7:0] HI_SOUND_DATA = 8'hBF;
  localparam logic [7:0] HI_PAGING     = 8'h7F;
  localparam logic [7:0] HI_EXTENDED   = 8'h1F;

  localparam logic [7:0] BORDER_RESET = 8'b11100111;
  localparam logic [7:0] IDLE_RESET   = 8'hFF;
  localparam logic [1:0] ROM_IS_RAM0  = 2'd3;
  localparam logic [1:0] ROM_BANK2    = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] port_low;
    logic [7:0] port_high;
    logic [7:0] write_value;
    logic [2:0] row_index;
    logic       tape_paused;
  } iopd_item_t;

  // Packed so the last field sits in the lowest bits of tdata.
  typedef struct packed {
    logic [3:0] pad;
    logic       mic_level;
    logic       speaker_level;
    logic [2:0] border_colour;
    logic       screen_high_page;
    logic [3:0] ram_bank;
    logic [1:0] rom_map;
    logic [7:0] read_data;
  } iopd_result_t;

  typedef struct packed {
    logic                     we;
    logic [KEY_ROW_IDX_W-1:0] row;
    logic [7:0]               data;
  } iopd_row_wr_t;

endpackage

// ===== rtl/core/io_port_decoder_and_memory_pager_top.sv =====
// Top level of the I/O port decoder and memory pager.
//
// Usage:
//   Requests come in on the s_ stream: one port read, port write or keyboard
//   row load per request (kind in s_tuser). Each request yields exactly one
//   result on the m_ stream with the read data and the current memory map,
//   border colour, speaker and mic levels after that request.
//   Configuration (extended paging enable, idle read byte) is written on the
//   cfg_ port, one register per cycle with cfg_we high, while no request is
//   in flight.
//   Path: a request accepted into the input register is decoded into the
//   result register, which drives m_tvalid and m_tdata.
//   Throughput: one request per cycle while m_tready is high; the decode is a
//   single pass of shallow logic over small registers and the keyboard row AND.
//   Stall: when m_tready is low the result register holds; one more request
//   waits in the input register, after which s_tready drops.
//   Reset (rst, synchronous): border 0xE7, paging and extended ports clear,
//   sound registers zero, keyboard rows all released, config to defaults;
//   both stages empty.
module io_port_decoder_and_memory_pager_top (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] port_low, [15:8] port_high, [23:16] write_value, [26:24] row_index,
  // [27] tape_paused, [31:28] zero
  input  logic [iopd_pkg::IN_DATA_W-1:0]      s_tdata,
  // [1:0] func
  input  logic [iopd_pkg::IN_USER_W-1:0]      s_tuser,
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] read_data, [9:8] rom_map, [13:10] ram_bank, [14] screen_high_page,
  // [17:15] border_colour, [18] speaker_level, [19] mic_level, [23:20] zero
  output logic [iopd_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [iopd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iopd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import iopd_pkg::*;

  logic         advance;
  logic         in_valid;
  logic         fire;
  logic         out_valid;
  iopd_item_t   item;
  iopd_result_t result;
  iopd_row_wr_t row_wr;
  logic [7:0]   key_data;

  // Execute stage moves when the result register is free or being drained.
  assign advance = !out_valid || m_tready;
  assign fire    = in_valid && advance;

  iopd_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  iopd_keyboard u_keyboard (
    .clk      (clk),
    .rst      (rst),
    .row_wr   (row_wr),
    .row_mask (item.port_high),
    .key_data (key_data)
  );

  iopd_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .m_tready  (m_tready),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_data  (key_data),
    .row_wr    (row_wr),
    .out_valid (out_valid),
    .result    (result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = result;

endmodule

// ===== rtl/core/iopd_input_stage.sv =====
// Input register: holds one request ahead of the execute stage.
module iopd_input_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [iopd_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [iopd_pkg::IN_USER_W-1:0] s_tuser,
  input  logic                          advance,
  output logic                          in_valid,
  output iopd_pkg::iopd_item_t          item
);
  import iopd_pkg::*;

  logic s_accept;

  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_accept || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item.func        <= s_tuser;
      item.port_low    <= s_tdata[7:0];
      item.port_high   <= s_tdata[15:8];
      item.write_value <= s_tdata[23:16];
      item.row_index   <= s_tdata[26:24];
      item.tape_paused <= s_tdata[27];
    end
  end

endmodule

// ===== rtl/core/iopd_keyboard.sv =====
// Keyboard row store and row-mask AND for reads of the keyboard port.
module iopd_keyboard (
  input  logic                  clk,
  input  logic                  rst,
  input  iopd_pkg::iopd_row_wr_t row_wr,
  input  logic [7:0]            row_mask,
  output logic [7:0]            key_data
);
  import iopd_pkg::*;

  logic [7:0] key_rows [KEY_ROW_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < KEY_ROW_COUNT; r++) key_rows[r] <= 8'hFF;
    end else if (row_wr.we) begin
      key_rows[row_wr.row] <= row_wr.data;
    end
  end

  // A row takes part when its mask bit is low.
  always_comb begin
    key_data = 8'hFF;
    for (int r = 0; r < KEY_ROW_COUNT; r++) begin
      if (!row_mask[r]) key_data = key_data & key_rows[r];
    end
  end

endmodule

// ===== rtl/core/iopd_exec.sv =====
// Execute stage: port decode, paging and border state, result register.
module iopd_exec (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic                               m_tready,
  input  iopd_pkg::iopd_item_t               item,
  input  logic                               cfg_we,
  input  logic [iopd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iopd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [7:0]                         key_data,
  output iopd_pkg::iopd_row_wr_t             row_wr,
  output logic                               out_valid,
  output iopd_pkg::iopd_result_t             result
);
  import iopd_pkg::*;

  // Config
  logic       ext_mode;
  logic [7:0] idle_value;

  // Port state (only the bits that are ever observed)
  logic [2:0] border;
  logic       mic;
  logic       speaker;
  logic       page_lock;
  logic [2:0] bank_sel;
  logic       rom_sel;
  logic       ext_ram_bit;
  logic [1:0] ext_rom_bits;
  logic [SOUND_SEL_W-1:0] sound_sel;
  logic [7:0] sound_regs [SOUND_REG_COUNT];
  logic [7:0] joy;
  logic [1:0] rom_slot;
  logic [3:0] ram_slot;
  logic       screen_slot;

  logic [2:0] border_next;
  logic       mic_next;
  logic       speaker_next;
  logic       page_lock_next;
  logic [2:0] bank_sel_next;
  logic       rom_sel_next;
  logic       ext_ram_bit_next;
  logic [1:0] ext_rom_bits_next;
  logic [SOUND_SEL_W-1:0] sound_sel_next;
  logic       sound_we;
  logic [7:0] joy_next;
  logic [1:0] rom_slot_next;
  logic [3:0] ram_slot_next;
  logic       screen_slot_next;
  logic [7:0] read_data;
  logic       is_write;
  logic       is_read;
  logic [7:0] v;

  assign v        = item.write_value;
  assign is_write = (item.func == FUNC_WRITE);
  assign is_read  = (item.func == FUNC_READ);

  always_comb begin
    read_data = idle_value;
    if (is_read) begin
      if (item.port_low == LO_SOUND) begin
        if (item.port_high == HI_SOUND_SEL) read_data = sound_regs[sound_sel];
      end else if (item.port_low == LO_JOY) begin
        read_data = joy;
      end else if (item.port_low == LO_ULA) begin
        read_data = key_data;
      end
    end
  end

  always_comb begin
    border_next       = border;
    mic_next          = mic;
    speaker_next      = speaker;
    page_lock_next    = page_lock;
    bank_sel_next     = bank_sel;
    rom_sel_next      = rom_sel;
    ext_ram_bit_next  = ext_ram_bit;
    ext_rom_bits_next = ext_rom_bits;
    sound_sel_next    = sound_sel;
    sound_we          = 1'b0;
    joy_next          = joy;
    rom_slot_next     = rom_slot;
    ram_slot_next     = ram_slot;
    screen_slot_next  = screen_slot;
    if (is_write) begin
      if (item.port_low == LO_JOY) begin
        joy_next = v;
      end else if (item.port_low == LO_ULA) begin
        border_next = v[2:0];
        mic_next    = v[3];
        if (item.tape_paused) speaker_next = v[4];
      end else if (item.port_low == LO_SOUND) begin
        if (item.port_high == HI_SOUND_SEL) begin
          sound_sel_next = v[SOUND_SEL_W-1:0];
        end else if (item.port_high == HI_SOUND_DATA) begin
          sound_we = item.tape_paused;
        end else if (item.port_high == HI_EXTENDED) begin
          if (ext_mode) begin
            ext_ram_bit_next  = v[4];
            ext_rom_bits_next = v[1:0];
            if (v[0])      rom_slot_next = ROM_IS_RAM0;
            else if (v[1]) rom_slot_next = ROM_BANK2;
            else           rom_slot_next = {1'b0, rom_sel};
            ram_slot_next = {v[4], bank_sel};
          end
        end else if (item.port_high == HI_PAGING) begin
          if (!page_lock) begin
            page_lock_next   = v[5];
            bank_sel_next    = v[2:0];
            rom_sel_next     = v[4];
            ram_slot_next    = {ext_ram_bit, v[2:0]};
            screen_slot_next = v[3];
            // Extended ROM select overrides the paging port ROM bit
            if (!ext_mode || ext_rom_bits == 2'b00) rom_slot_next = {1'b0, v[4]};
          end
        end
      end
    end
  end

  always_comb begin
    row_wr.we   = fire && (item.func == FUNC_ROW_LOAD) && (int'(item.row_index) < KEY_ROW_COUNT);
    row_wr.row  = item.row_index[KEY_ROW_IDX_W-1:0];
    row_wr.data = v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_mode   <= 1'b0;
      idle_value <= IDLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXT_MODE:  ext_mode   <= cfg_wdata[0];
        CFG_IDLE_READ: idle_value <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      border       <= BORDER_RESET[2:0];
      mic          <= BORDER_RESET[3];
      speaker      <= 1'b0;
      page_lock    <= 1'b0;
      bank_sel     <= '0;
      rom_sel      <= 1'b0;
      ext_ram_bit  <= 1'b0;
      ext_rom_bits <= '0;
      sound_sel    <= '0;
      joy          <= '0;
      rom_slot     <= '0;
      ram_slot     <= '0;
      screen_slot  <= 1'b0;
      for (int i = 0; i < SOUND_REG_COUNT; i++) sound_regs[i] <= '0;
    end else if (fire) begin
      border       <= border_next;
      mic          <= mic_next;
      speaker      <= speaker_next;
      page_lock    <= page_lock_next;
      bank_sel     <= bank_sel_next;
      rom_sel      <= rom_sel_next;
      ext_ram_bit  <= ext_ram_bit_next;
      ext_rom_bits <= ext_rom_bits_next;
      sound_sel    <= sound_sel_next;
      joy          <= joy_next;
      rom_slot     <= rom_slot_next;
      ram_slot     <= ram_slot_next;
      screen_slot  <= screen_slot_next;
      if (sound_we) sound_regs[sound_sel] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.pad              <= '0;
      result.read_data        <= read_data;
      result.rom_map          <= rom_slot_next;
      result.ram_bank         <= ram_slot_next;
      result.screen_high_page <= screen_slot_next;
      result.border_colour    <= border_next;
      result.speaker_level    <= speaker_next;
      result.mic_level        <= mic_next;
    end
  end

endmodule
